@@ sv/sfc_pkg.sv @@
`timescale 1ns / 1ps

package sfc_pkg;

    // input operation codes
    localparam logic [1:0] FUNC_TX_BEGIN = 2'd0;
    localparam logic [1:0] FUNC_TX_DATA  = 2'd1;
    localparam logic [1:0] FUNC_RX_FIRST = 2'd2;
    localparam logic [1:0] FUNC_RX_NEXT  = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_TX_BYTE   = 2'd0;
    localparam logic [1:0] KIND_RX_BYTE   = 2'd1;
    localparam logic [1:0] KIND_RX_STATUS = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEADER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CTRL_BYTE    = 2'd1;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [15:0] FRAME_HEADER_RST = 16'h6655;
    localparam logic [15:0] CRC_POLY         = 16'h1021;

    // frame byte offsets
    localparam logic [3:0] OFS_HDR_LO  = 4'd0;
    localparam logic [3:0] OFS_HDR_HI  = 4'd1;
    localparam logic [3:0] OFS_CTRL    = 4'd2;
    localparam logic [3:0] OFS_LEN_LO  = 4'd3;
    localparam logic [3:0] OFS_LEN_HI  = 4'd4;
    localparam logic [3:0] OFS_SEQ_LO  = 4'd5;
    localparam logic [3:0] OFS_SEQ_HI  = 4'd6;
    localparam logic [3:0] OFS_CMD     = 4'd7;
    localparam logic [3:0] OFS_PAYLOAD = 4'd8;
    localparam logic [3:0] OFS_CRC_HI  = 4'd9;

    localparam logic [16:0] RX_IDLE = 17'h1FFFF;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  cmd_id;
        logic [15:0] payload_len;
        logic [7:0]  data_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  out_kind;
        logic [7:0]  out_byte;
        logic        tx_frame_end;
        logic [7:0]  rx_cmd_id;
        logic [15:0] rx_seq;
        logic [15:0] rx_len;
        logic        rx_crc_ok;
        logic        last_of_run;
    } t_out_item;

    // crc-16/xmodem over one byte, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ sv/serial_frame_codec_crc16_top.sv @@
`timescale 1ns / 1ps

// serial frame codec with crc-16/xmodem, transmit and receive sharing one
// sequence counter.
// input channel: i_in_valid / o_in_stall carry one item per transaction
// (func, cmd_id, payload_len, data_byte). output channel: o_out_valid /
// i_out_stall carry one result per transaction.
// configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 frame header, 1 control byte); other indexes are dropped. write only
// while the block is idle.
// a taken item is held in the current-item register and its first result
// then moves to the output register; results follow at one output byte
// per cycle while the output is not stalled, set by the single output
// register and the one-byte crc step. a begin item emits the header, plus
// the crc for a zero length frame; a payload byte emits itself, plus the
// crc if it is the last. the next item is taken in the same cycle the last
// result of the current one moves to the output register.
// reset (synchronous, active low) clears the counters, crc state and both
// valids, and restores the default frame header and control byte.
// when the receiver stalls the result holds in the output register, the
// current item stops advancing and o_in_stall rises once that item has
// another result to emit.

module serial_frame_codec_crc16_top (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [sfc_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [sfc_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  sfc_pkg::t_in_item                     i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output sfc_pkg::t_out_item                    o_out_data
);

    localparam logic [3:0] STEP_FIRST     = 4'd0;
    localparam logic [3:0] STEP_PL_CRC_LO = 4'd1;

    // configuration
    logic [15:0] r_frame_header;
    logic [7:0]  r_ctrl_byte;

    // item being expanded
    logic               r_cur_valid;
    sfc_pkg::t_in_item  r_cur;
    logic [3:0]         r_step;

    // output register
    logic               r_out_valid;
    sfc_pkg::t_out_item r_out;

    // codec state
    logic [15:0] r_seq,        n_seq;
    logic        r_tx_active,  n_tx_active;
    logic [15:0] r_tx_rem,     n_tx_rem;
    logic [15:0] r_tx_crc,     n_tx_crc;
    logic [16:0] r_rx_index,   n_rx_index;
    logic [15:0] r_rx_length,  n_rx_length;
    logic [15:0] r_rx_crc,     n_rx_crc;
    logic [7:0]  r_rx_crc_low, n_rx_crc_low;
    logic [15:0] r_rx_seq,     n_rx_seq;
    logic [7:0]  r_rx_cmd,     n_rx_cmd;

    logic               has_res;
    logic               last;
    sfc_pkg::t_out_item res;
    logic               out_adv;
    logic               fire;

    // scratch for the current step
    logic [7:0]  tx_b;
    logic [15:0] crc_in;
    logic        rx_first;
    logic [16:0] idx_e;
    logic [15:0] crc_e;
    logic [15:0] len_e;
    logic [15:0] seq_e;
    logic [7:0]  cmd_e;
    logic [7:0]  low_e;
    logic [16:0] crc_at;
    logic        crc_ok;

    always_comb begin
        n_seq        = r_seq;
        n_tx_active  = r_tx_active;
        n_tx_rem     = r_tx_rem;
        n_tx_crc     = r_tx_crc;
        n_rx_index   = r_rx_index;
        n_rx_length  = r_rx_length;
        n_rx_crc     = r_rx_crc;
        n_rx_crc_low = r_rx_crc_low;
        n_rx_seq     = r_rx_seq;
        n_rx_cmd     = r_rx_cmd;
        has_res      = 1'b0;
        last         = 1'b1;
        res          = '0;
        tx_b         = '0;
        crc_in       = r_tx_crc;
        rx_first     = (r_cur.func == sfc_pkg::FUNC_RX_FIRST);
        idx_e        = rx_first ? 17'd0 : r_rx_index;
        crc_e        = rx_first ? 16'd0 : r_rx_crc;
        len_e        = rx_first ? 16'd0 : r_rx_length;
        seq_e        = rx_first ? 16'd0 : r_rx_seq;
        cmd_e        = rx_first ? 8'd0  : r_rx_cmd;
        low_e        = rx_first ? 8'd0  : r_rx_crc_low;
        crc_at       = 17'(sfc_pkg::OFS_PAYLOAD) + {1'b0, len_e};
        crc_ok       = ({r_cur.data_byte, low_e} == crc_e);

        case (r_cur.func)
            sfc_pkg::FUNC_TX_BEGIN: begin
                has_res = 1'b1;
                res.out_kind = sfc_pkg::KIND_TX_BYTE;
                case (r_step)
                    sfc_pkg::OFS_HDR_LO: tx_b = r_frame_header[7:0];
                    sfc_pkg::OFS_HDR_HI: tx_b = r_frame_header[15:8];
                    sfc_pkg::OFS_CTRL:   tx_b = r_ctrl_byte;
                    sfc_pkg::OFS_LEN_LO: tx_b = r_cur.payload_len[7:0];
                    sfc_pkg::OFS_LEN_HI: tx_b = r_cur.payload_len[15:8];
                    sfc_pkg::OFS_SEQ_LO: tx_b = r_seq[7:0];
                    sfc_pkg::OFS_SEQ_HI: tx_b = r_seq[15:8];
                    sfc_pkg::OFS_CMD:    tx_b = r_cur.cmd_id;
                    sfc_pkg::OFS_PAYLOAD: tx_b = r_tx_crc[7:0];
                    default:             tx_b = r_tx_crc[15:8];
                endcase
                res.out_byte = tx_b;
                if (r_step <= sfc_pkg::OFS_CMD) begin
                    // header byte: feed the crc, counter advances on the first
                    if (r_step == STEP_FIRST) begin
                        crc_in = '0;
                        n_seq  = r_seq + 16'd1;
                    end
                    n_tx_crc = sfc_pkg::crc_byte(crc_in, tx_b);
                    last     = 1'b0;
                    if (r_step == sfc_pkg::OFS_CMD) begin
                        n_tx_active = (r_cur.payload_len != 16'd0);
                        n_tx_rem    = r_cur.payload_len;
                        last        = (r_cur.payload_len != 16'd0);
                    end
                end else if (r_step == sfc_pkg::OFS_PAYLOAD) begin
                    last = 1'b0;
                end else begin
                    res.tx_frame_end = 1'b1;
                    n_tx_active      = 1'b0;
                    n_tx_rem         = '0;
                end
            end
            sfc_pkg::FUNC_TX_DATA: begin
                res.out_kind = sfc_pkg::KIND_TX_BYTE;
                if (r_step == STEP_FIRST) begin
                    has_res = r_tx_active;
                    if (r_tx_active) begin
                        res.out_byte = r_cur.data_byte;
                        n_tx_crc     = sfc_pkg::crc_byte(r_tx_crc, r_cur.data_byte);
                        n_tx_rem     = r_tx_rem - 16'd1;
                        last         = (r_tx_rem != 16'd1);
                    end
                end else if (r_step == STEP_PL_CRC_LO) begin
                    has_res      = 1'b1;
                    res.out_byte = r_tx_crc[7:0];
                    last         = 1'b0;
                end else begin
                    has_res          = 1'b1;
                    res.out_byte     = r_tx_crc[15:8];
                    res.tx_frame_end = 1'b1;
                    n_tx_active      = 1'b0;
                    n_tx_rem         = '0;
                end
            end
            default: begin
                // receive: a first byte restarts parsing at offset zero
                n_rx_crc     = crc_e;
                n_rx_length  = len_e;
                n_rx_seq     = seq_e;
                n_rx_cmd     = cmd_e;
                n_rx_crc_low = low_e;
                n_rx_index   = idx_e;
                if (idx_e == sfc_pkg::RX_IDLE) begin
                    has_res = 1'b0;
                end else if (idx_e < 17'(sfc_pkg::OFS_PAYLOAD)) begin
                    n_rx_crc   = sfc_pkg::crc_byte(crc_e, r_cur.data_byte);
                    n_rx_index = idx_e + 17'd1;
                    if (idx_e == 17'(sfc_pkg::OFS_LEN_LO)) begin
                        n_rx_length = {len_e[15:8], r_cur.data_byte};
                    end else if (idx_e == 17'(sfc_pkg::OFS_LEN_HI)) begin
                        n_rx_length = {r_cur.data_byte, len_e[7:0]};
                    end else if (idx_e == 17'(sfc_pkg::OFS_SEQ_LO)) begin
                        n_rx_seq = {seq_e[15:8], r_cur.data_byte};
                    end else if (idx_e == 17'(sfc_pkg::OFS_SEQ_HI)) begin
                        n_rx_seq = {r_cur.data_byte, seq_e[7:0]};
                    end else if (idx_e == 17'(sfc_pkg::OFS_CMD)) begin
                        n_rx_cmd = r_cur.data_byte;
                    end
                end else if (idx_e < crc_at) begin
                    n_rx_crc     = sfc_pkg::crc_byte(crc_e, r_cur.data_byte);
                    n_rx_index   = idx_e + 17'd1;
                    has_res      = 1'b1;
                    res.out_kind = sfc_pkg::KIND_RX_BYTE;
                    res.out_byte = r_cur.data_byte;
                end else if (idx_e == crc_at) begin
                    n_rx_crc_low = r_cur.data_byte;
                    n_rx_index   = idx_e + 17'd1;
                end else begin
                    has_res       = 1'b1;
                    res.out_kind  = sfc_pkg::KIND_RX_STATUS;
                    res.rx_cmd_id = cmd_e;
                    res.rx_seq    = seq_e;
                    res.rx_len    = len_e;
                    res.rx_crc_ok = crc_ok;
                    if (crc_ok) begin
                        n_seq = seq_e;
                    end
                    n_rx_index = sfc_pkg::RX_IDLE;
                end
            end
        endcase
        res.last_of_run = last;
    end

    // output register frees up when empty or being taken this cycle
    assign out_adv    = !r_out_valid || !i_out_stall;
    assign fire       = r_cur_valid && (out_adv || !has_res);
    assign o_in_stall = r_cur_valid && !(fire && last);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_header <= sfc_pkg::FRAME_HEADER_RST;
            r_ctrl_byte    <= '0;
            r_cur_valid    <= 1'b0;
            r_step         <= '0;
            r_out_valid    <= 1'b0;
            r_seq          <= '0;
            r_tx_active    <= 1'b0;
            r_tx_rem       <= '0;
            r_tx_crc       <= '0;
            r_rx_index     <= '0;
            r_rx_length    <= '0;
            r_rx_crc       <= '0;
            r_rx_crc_low   <= '0;
            r_rx_seq       <= '0;
            r_rx_cmd       <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sfc_pkg::CFG_FRAME_HEADER: r_frame_header <= i_cfg_data[15:0];
                    sfc_pkg::CFG_CTRL_BYTE:    r_ctrl_byte    <= i_cfg_data[7:0];
                    default: ;
                endcase
            end

            if (fire) begin
                r_seq        <= n_seq;
                r_tx_active  <= n_tx_active;
                r_tx_rem     <= n_tx_rem;
                r_tx_crc     <= n_tx_crc;
                r_rx_index   <= n_rx_index;
                r_rx_length  <= n_rx_length;
                r_rx_crc     <= n_rx_crc;
                r_rx_crc_low <= n_rx_crc_low;
                r_rx_seq     <= n_rx_seq;
                r_rx_cmd     <= n_rx_cmd;
                r_step       <= last ? STEP_FIRST : r_step + 4'd1;
            end

            // take a new transaction once the current item is done
            if (i_in_valid && !o_in_stall) begin
                r_cur_valid <= 1'b1;
                r_cur       <= i_in_data;
            end else if (fire && last) begin
                r_cur_valid <= 1'b0;
            end

            if (fire && has_res) begin
                r_out_valid <= 1'b1;
                r_out       <= res;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // a step in progress always belongs to a held item
    a_step_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != STEP_FIRST) |-> r_cur_valid)
        else $error("expansion step without a current item");

    // never overwrite a stalled result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !(fire && has_res))
        else $error("result overwritten while output stalled");

    // an open transmit frame between items always has bytes left
    a_tx_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_active && !r_cur_valid) |-> (r_tx_rem != 16'd0))
        else $error("open transmit frame with no bytes remaining");

    // receive index never passes the second crc byte unless idle
    a_rx_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_index == sfc_pkg::RX_IDLE) || (r_rx_index <= {1'b0, r_rx_length} + 17'd9))
        else $error("receive index beyond frame end");

    // a begin item returns to its first step after its closing crc byte
    a_begin_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_cur.func == sfc_pkg::FUNC_TX_BEGIN && r_step == sfc_pkg::OFS_CRC_HI)
        |=> (r_step == STEP_FIRST))
        else $error("begin item ran past its closing crc byte");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

// frame codec bench: transmit framing with crc append, receive parsing with
// crc check, shared sequence counter. a behavioral copy of the codec runs
// beside the block, and every result is compared against it in order.

module tb_top;

    localparam int unsigned IDLE_MAX    = 16;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned HDR_BYTES   = 8;

    // indexes past the last register, writes there must be dropped
    localparam logic [sfc_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [sfc_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    // ------------------------------------------------------------------
    // block ports, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [sfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [sfc_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           i_in_valid  = 1'b0;
    logic                           o_in_stall;
    sfc_pkg::t_in_item              i_in_data   = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    sfc_pkg::t_out_item             o_out_data;

    serial_frame_codec_crc16_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // codec state as the bench sees it (reset values)
    // ------------------------------------------------------------------
    logic [15:0] hdr_word   = sfc_pkg::FRAME_HEADER_RST;
    logic [7:0]  ctrl_val   = 8'h00;
    logic [15:0] seq_ctr    = '0;
    logic        tx_open    = 1'b0;
    logic [15:0] tx_left    = '0;
    logic [15:0] tx_crc_acc = '0;
    logic [16:0] rx_pos     = '0;
    logic [15:0] rx_len_f   = '0;
    logic [15:0] rx_crc_acc = '0;
    logic [7:0]  rx_crc_lo  = '0;
    logic [15:0] rx_seq_f   = '0;
    logic [7:0]  rx_cmd_f   = '0;

    sfc_pkg::t_out_item frame_results[$];  // results still owed by the block, oldest first
    logic [7:0]  link_bytes[$];     // frame being fed to the receive path
    int          active_items = 0;  // transactions that did something
    int          mismatch_cnt = 0;

    // idle shaping: sender gap before the next transaction, receiver hold-off
    int          in_idle_max  = IDLE_MAX;
    int          out_idle_max = IDLE_MAX;
    int          in_gap       = 1;
    int          rx_hold_req  = 0;

    // crc-16/xmodem, one byte, msb first
    function automatic logic [15:0] crc16_xmodem_next(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        repeat (8) c = c[15] ? ((c << 1) ^ sfc_pkg::CRC_POLY) : (c << 1);
        return c;
    endfunction

    function automatic sfc_pkg::t_out_item byte_result(logic [1:0] kind, logic [7:0] b,
                                                       logic fin);
        sfc_pkg::t_out_item r;
        r = '0;
        r.out_kind     = kind;
        r.out_byte     = b;
        r.tx_frame_end = fin;
        return r;
    endfunction

    // work out what one accepted transaction produces and queue it
    task automatic predict_frame_item(input sfc_pkg::t_in_item it);
        sfc_pkg::t_out_item run[$];
        sfc_pkg::t_out_item st;
        logic [7:0]  hdr[HDR_BYTES];
        logic [7:0]  b;
        logic [16:0] crc_at;
        b = it.data_byte;
        case (it.func)
            sfc_pkg::FUNC_TX_BEGIN: begin
                // a new frame always wins over one still open
                active_items++;
                seq_ctr = seq_ctr + 16'd1;
                hdr = '{hdr_word[7:0], hdr_word[15:8], ctrl_val, it.payload_len[7:0],
                        it.payload_len[15:8], seq_ctr[7:0], seq_ctr[15:8], it.cmd_id};
                tx_crc_acc = '0;
                foreach (hdr[i]) begin
                    tx_crc_acc = crc16_xmodem_next(tx_crc_acc, hdr[i]);
                    run.push_back(byte_result(sfc_pkg::KIND_TX_BYTE, hdr[i], 1'b0));
                end
                tx_open = 1'b1;
                tx_left = it.payload_len;
            end
            sfc_pkg::FUNC_TX_DATA: begin
                // payload with no open frame just falls on the floor
                if (tx_open) begin
                    active_items++;
                    tx_crc_acc = crc16_xmodem_next(tx_crc_acc, b);
                    run.push_back(byte_result(sfc_pkg::KIND_TX_BYTE, b, 1'b0));
                    tx_left = tx_left - 16'd1;
                end
            end
            default: begin
                if (it.func == sfc_pkg::FUNC_RX_FIRST) begin
                    rx_pos     = '0;
                    rx_crc_acc = '0;
                    rx_len_f   = '0;
                    rx_seq_f   = '0;
                    rx_cmd_f   = '0;
                    rx_crc_lo  = '0;
                end
                if (rx_pos != sfc_pkg::RX_IDLE) begin
                    active_items++;
                    crc_at = 17'(sfc_pkg::OFS_PAYLOAD) + 17'(rx_len_f);
                    if (rx_pos < 17'(sfc_pkg::OFS_PAYLOAD)) begin
                        rx_crc_acc = crc16_xmodem_next(rx_crc_acc, b);
                        case (rx_pos[3:0])
                            sfc_pkg::OFS_LEN_LO: rx_len_f[7:0]  = b;
                            sfc_pkg::OFS_LEN_HI: rx_len_f[15:8] = b;
                            sfc_pkg::OFS_SEQ_LO: rx_seq_f[7:0]  = b;
                            sfc_pkg::OFS_SEQ_HI: rx_seq_f[15:8] = b;
                            sfc_pkg::OFS_CMD:    rx_cmd_f       = b;
                            default: ;
                        endcase
                        rx_pos = rx_pos + 17'd1;
                    end else if (rx_pos < crc_at) begin
                        rx_crc_acc = crc16_xmodem_next(rx_crc_acc, b);
                        run.push_back(byte_result(sfc_pkg::KIND_RX_BYTE, b, 1'b0));
                        rx_pos = rx_pos + 17'd1;
                    end else if (rx_pos == crc_at) begin
                        rx_crc_lo = b;
                        rx_pos    = rx_pos + 17'd1;
                    end else begin
                        st = '0;
                        st.out_kind  = sfc_pkg::KIND_RX_STATUS;
                        st.rx_cmd_id = rx_cmd_f;
                        st.rx_seq    = rx_seq_f;
                        st.rx_len    = rx_len_f;
                        st.rx_crc_ok = ({b, rx_crc_lo} == rx_crc_acc);
                        run.push_back(st);
                        // only a clean frame moves the shared counter
                        if (st.rx_crc_ok) seq_ctr = rx_seq_f;
                        rx_pos = sfc_pkg::RX_IDLE;
                    end
                end
            end
        endcase
        // payload used up (or zero length): crc goes out low byte first
        if (tx_open && tx_left == 16'd0) begin
            run.push_back(byte_result(sfc_pkg::KIND_TX_BYTE, tx_crc_acc[7:0], 1'b0));
            run.push_back(byte_result(sfc_pkg::KIND_TX_BYTE, tx_crc_acc[15:8], 1'b1));
            tx_open = 1'b0;
        end
        if (run.size() != 0) run[run.size() - 1].last_of_run = 1'b1;
        foreach (run[i]) frame_results.push_back(run[i]);
    endtask

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------
    function automatic sfc_pkg::t_in_item random_item();
        sfc_pkg::t_in_item it;
        it.func        = 2'($urandom);
        it.cmd_id      = 8'($urandom);
        it.payload_len = 16'($urandom);
        it.data_byte   = 8'($urandom);
        return it;
    endfunction

    // one transaction; valid stays up across back-to-back items and is only
    // dropped when a gap follows
    task automatic send_item(input sfc_pkg::t_in_item it);
        if (in_gap != 0) repeat (in_gap) @(posedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        predict_frame_item(it);
        in_gap = $urandom_range(in_idle_max, 0);
        if (in_gap != 0) i_in_valid <= 1'b0;
    endtask

    // unused fields stay random so every input bit toggles
    task automatic tx_begin(input logic [7:0] cmd, input logic [15:0] len);
        sfc_pkg::t_in_item it;
        it = random_item();
        it.func        = sfc_pkg::FUNC_TX_BEGIN;
        it.cmd_id      = cmd;
        it.payload_len = len;
        send_item(it);
    endtask

    task automatic send_byte(input logic [1:0] func, input logic [7:0] b);
        sfc_pkg::t_in_item it;
        it = random_item();
        it.func      = func;
        it.data_byte = b;
        send_item(it);
    endtask

    // well-formed link frame with a correct crc, random start word and control
    function automatic void make_link_frame(logic [7:0] cmd, logic [15:0] seq,
                                            logic [15:0] len);
        logic [15:0] crc;
        logic [15:0] hw;
        hw = 16'($urandom);
        link_bytes = '{hw[7:0], hw[15:8], 8'($urandom), len[7:0], len[15:8],
                       seq[7:0], seq[15:8], cmd};
        repeat (len) link_bytes.push_back(8'($urandom));
        crc = '0;
        foreach (link_bytes[i]) crc = crc16_xmodem_next(crc, link_bytes[i]);
        link_bytes.push_back(crc[7:0]);
        link_bytes.push_back(crc[15:8]);
    endfunction

    task automatic send_link_bytes(input logic [1:0] first_func);
        foreach (link_bytes[i]) begin
            send_byte((i == 0) ? first_func : sfc_pkg::FUNC_RX_NEXT, link_bytes[i]);
        end
    endtask

    // drop valid, let every owed result come back, then let the block settle
    task automatic wait_results_drained();
        if (in_gap == 0) begin
            i_in_valid <= 1'b0;
            in_gap = 1;
        end
        while (frame_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [sfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sfc_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == sfc_pkg::CFG_FRAME_HEADER) begin
            hdr_word = val;
        end else if (idx == sfc_pkg::CFG_CTRL_BYTE) begin
            ctrl_val = val[7:0];
        end
        @(posedge i_clk);
    endtask

    // mostly clean frames both ways with random content, plus damaged,
    // cut-short and abandoned frames and some loose noise
    task automatic run_random_traffic(input int n_items);
        int goal;
        int pick;
        int len;
        int cnt;
        int cut;
        goal = active_items + n_items;
        while (active_items < goal) begin
            pick = $urandom_range(99, 0);
            if (pick < 40) begin
                if (pick < 4) begin
                    len = $urandom_range(65535, 0);
                end else if (pick < 12) begin
                    len = $urandom_range(24, 7);
                end else begin
                    len = $urandom_range(6, 0);
                end
                // a few frames are left open and get abandoned later
                cnt = (pick < 6) ? $urandom_range(3, 0) : len;
                tx_begin(8'($urandom), 16'(len));
                repeat (cnt) send_byte(sfc_pkg::FUNC_TX_DATA, 8'($urandom));
            end else if (pick < 88) begin
                len = (pick < 46) ? $urandom_range(20, 7) : $urandom_range(6, 0);
                make_link_frame(8'($urandom), 16'($urandom), 16'(len));
                if (pick >= 76 && pick < 84) begin
                    link_bytes[$urandom_range(link_bytes.size() - 1, 0)] ^=
                        8'($urandom_range(255, 1));
                end else if (pick >= 84) begin
                    cut = $urandom_range(link_bytes.size() - 1, 1);
                    while (link_bytes.size() > cut) void'(link_bytes.pop_back());
                end
                send_link_bytes((pick == 87) ? sfc_pkg::FUNC_RX_NEXT
                                             : sfc_pkg::FUNC_RX_FIRST);
            end else begin
                repeat ($urandom_range(3, 1)) send_item(random_item());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // a frame fed only with next-byte marks right after reset parses from
    // offset zero; its sequence of all ones loads the counter, and a stray
    // byte after the status is ignored
    task automatic test_receive_after_reset();
        make_link_frame(8'hA5, 16'hFFFF, 16'd0);
        send_link_bytes(sfc_pkg::FUNC_RX_NEXT);
        send_byte(sfc_pkg::FUNC_RX_NEXT, 8'hFF);
    endtask

    task automatic test_transmit_cases();
        send_byte(sfc_pkg::FUNC_TX_DATA, 8'hFF);   // nothing open, no result
        tx_begin(8'hFF, 16'd0);           // counter wraps to zero, crc follows header
        tx_begin(8'h00, 16'hFFFF);
        send_byte(sfc_pkg::FUNC_TX_DATA, 8'h00);
        tx_begin(8'h5A, 16'd1);           // abandons the long frame
        send_byte(sfc_pkg::FUNC_TX_DATA, 8'hFF);
    endtask

    // header cut short then a new first byte restarts the parse; that frame
    // carries a bad crc and must not touch the counter
    task automatic test_receive_errors();
        make_link_frame(8'h3C, 16'h1234, 16'd2);
        while (link_bytes.size() > 3) void'(link_bytes.pop_back());
        send_link_bytes(sfc_pkg::FUNC_RX_FIRST);
        make_link_frame(8'h00, 16'h0000, 16'd0);
        link_bytes[link_bytes.size() - 1] ^= 8'h80;
        send_link_bytes(sfc_pkg::FUNC_RX_FIRST);
        tx_begin(8'h81, 16'd0);
    endtask

    // register sweep: all zeros, all ones (upper control bits dropped), random,
    // with writes to unused indexes in the random phases
    task automatic test_config_registers();
        logic [15:0] hw;
        logic [15:0] cw;
        for (int ph = 0; ph < 4; ph++) begin
            wait_results_drained();
            case (ph)
                0: begin
                    hw = 16'h0000;
                    cw = 16'h0000;
                end
                1: begin
                    hw = 16'hFFFF;
                    cw = 16'hFFFF;
                end
                default: begin
                    hw = 16'($urandom);
                    cw = 16'($urandom);
                end
            endcase
            cfg_write(sfc_pkg::CFG_FRAME_HEADER, hw);
            cfg_write(sfc_pkg::CFG_CTRL_BYTE, cw);
            if (ph >= 2) begin
                cfg_write(CFG_SPARE_2, 16'($urandom));
                cfg_write(CFG_SPARE_3, 16'($urandom));
            end
            run_random_traffic(25);
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps pushing
    // ten-byte frames, so the block backs up into its input; then the
    // sender waits for everything to drain before going on
    task automatic test_output_hold_off();
        int saved;
        wait_results_drained();
        saved = in_idle_max;
        in_idle_max = 0;
        rx_hold_req = 120;
        repeat (6) tx_begin(8'($urandom), 16'd0);
        in_idle_max = saved;
        wait_results_drained();
        run_random_traffic(20);
    endtask

    task automatic test_back_to_back();
        in_idle_max  = 0;
        out_idle_max = 0;
        run_random_traffic(30);
        in_idle_max  = IDLE_MAX;
        out_idle_max = IDLE_MAX;
    endtask

    task automatic test_mixed_traffic();
        run_random_traffic(20);
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_receive_after_reset();
        test_transmit_cases();
        test_receive_errors();
        test_config_registers();
        test_output_hold_off();
        test_back_to_back();
        test_mixed_traffic();
        wait_results_drained();
        repeat (16) @(posedge i_clk);
        if (mismatch_cnt == 0 && frame_results.size() == 0) begin
            $display("PASS serial_frame_codec_crc16_top");
        end else begin
            $display("FAIL serial_frame_codec_crc16_top");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // output side: random hold-off per result, then compare
    // ------------------------------------------------------------------
    function automatic string result_text(sfc_pkg::t_out_item r);
        return $sformatf("kind=%0d byte=%h end=%b cmd=%h seq=%h len=%h ok=%b last=%b",
                         r.out_kind, r.out_byte, r.tx_frame_end, r.rx_cmd_id, r.rx_seq,
                         r.rx_len, r.rx_crc_ok, r.last_of_run);
    endfunction

    function automatic string field_diffs(sfc_pkg::t_out_item e, sfc_pkg::t_out_item g);
        string s;
        s = "";
        if (g.out_kind !== e.out_kind) s = {s, " out_kind"};
        if (g.out_byte !== e.out_byte) s = {s, " out_byte"};
        if (g.tx_frame_end !== e.tx_frame_end) s = {s, " tx_frame_end"};
        if (g.rx_cmd_id !== e.rx_cmd_id) s = {s, " rx_cmd_id"};
        if (g.rx_seq !== e.rx_seq) s = {s, " rx_seq"};
        if (g.rx_len !== e.rx_len) s = {s, " rx_len"};
        if (g.rx_crc_ok !== e.rx_crc_ok) s = {s, " rx_crc_ok"};
        if (g.last_of_run !== e.last_of_run) s = {s, " last_of_run"};
        return s;
    endfunction

    task automatic log_mismatch(input string what, input sfc_pkg::t_out_item e,
                                input sfc_pkg::t_out_item g);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS) begin
            $display("%0t: %s\n  expected %s\n  actual   %s", $time, what,
                     result_text(e), result_text(g));
        end
    endtask

    initial begin : result_checker
        sfc_pkg::t_out_item exp_r;
        string     bad;
        int        hold;
        wait (i_rst_n === 1'b1);
        forever begin
            // a requested long hold-off takes the place of the random one
            hold = (rx_hold_req != 0) ? rx_hold_req : $urandom_range(out_idle_max, 0);
            rx_hold_req = 0;
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            if (frame_results.size() == 0) begin
                log_mismatch("result with nothing expected", '0, o_out_data);
            end else begin
                exp_r = frame_results.pop_front();
                bad = field_diffs(exp_r, o_out_data);
                if (bad != "") log_mismatch({"field mismatch:", bad}, exp_r, o_out_data);
            end
        end
    end

    // run limit, far above the slowest legal run
    initial begin : watchdog
        #1_000_000;
        $display("FAIL serial_frame_codec_crc16_top");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/sfc_pkg.sv
sv/serial_frame_codec_crc16_top.sv
verif/tb_top.sv
